// ===== rtl/core/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-32 decoder.
// Used by u8dec_lead, u8dec_accum and utf8_to_utf32_decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package u8dec_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_STRAY     = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    // Payload masks of a lead byte, indexed by the number of payload bits.
    localparam logic [7:0] LEAD_MASK [0:8] = '{
        8'h00, 8'h01, 8'h03, 8'h07, 8'h0f, 8'h1f, 8'h3f, 8'h7f, 8'hff
    };

    // Classes of a byte seen while no sequence is open.
    typedef enum logic [1:0] {
        LK_SINGLE,
        LK_STRAY,
        LK_INVALID,
        LK_LEAD
    } t_lead_kind;

    // Decoded view of a byte taken as a lead byte.
    typedef struct packed {
        t_lead_kind  kind;
        logic [2:0]  remain;
        logic [7:0]  payload;
    } t_lead_info;

    // One result beat, before the output register.
    typedef struct packed {
        logic        valid;
        logic [31:0] code_point;
        logic [1:0]  status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/utf8_to_utf32_decoder.sv =====
// Top level of the UTF-8 to UTF-32 decoder: input register, output register
// and flow control. Depends on u8dec_pkg and u8dec_accum.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one byte of UTF-8 text per beat and returns at most one
// 32-bit code point with a two-bit status per byte: a single-byte character
// right away, a multi-byte character on its last byte, and an error beat
// (code point zero) for a stray continuation byte, a 0xFF byte in idle, or
// text whose end mark falls inside a sequence. While the output side keeps
// up it accepts one byte every cycle without gaps. An accepted byte waits in
// the input register, and its result is then registered in the output
// register, from which it is taken at an edge where i_stall is low. A result
// held by an output stall stalls the input once the input register is also
// occupied. The sequence state in u8dec_accum is updated as each byte moves
// on from the input register. Continuation prefixes are not checked and the
// value wraps at 32 bits.
module utf8_to_utf32_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_text,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_code_point,
    output logic [1:0]       o_status
);
    import u8dec_pkg::*;

    logic        r_in_valid;
    logic        n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_code_point;
    logic [1:0]  r_status;
    logic        w_out_free;
    logic        w_fire;
    logic        w_accept;
    t_result     w_result;

    // The output register frees up when empty or when its beat is taken.
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_stall    = r_in_valid && !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    u8dec_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    // Input register occupancy.
    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
    end

    // Output register occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = w_result.valid;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_end_of_text;
        end
        if (w_fire && w_result.valid) begin
            r_code_point <= w_result.code_point;
            r_status     <= w_result.status;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_status     = r_status;

    // Nothing is shown in the cycle after reset.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat valid after reset");

    // Every error beat carries a zero code point.
    a_error_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_code_point == 32'd0))
        else $error("error beat with nonzero code point");

    // Input stalls only while a byte waits behind a blocked output.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked output");

    // A byte held back keeps its place in the input register.
    a_hold_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_in_valid && $stable(r_in_byte) && $stable(r_in_last)))
        else $error("stalled input byte lost");

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_lead.sv =====
// Lead byte classifier: counts leading ones and extracts the payload bits.
// Depends on u8dec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_lead (
    input  wire logic [7:0]           i_byte,
    output u8dec_pkg::t_lead_info     o_lead
);
    import u8dec_pkg::*;

    logic [3:0] w_ones;
    logic       w_run;

    // Count the run of ones from the top bit down.
    always_comb begin
        w_ones = 4'd0;
        w_run  = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (w_run && i_byte[i]) begin
                w_ones = w_ones + 4'd1;
            end else begin
                w_run = 1'b0;
            end
        end
    end

    // Classify the byte and keep the bits below the terminating zero.
    always_comb begin
        o_lead.remain  = 3'd0;
        o_lead.payload = 8'd0;
        case (w_ones)
            4'd0: begin
                o_lead.kind = LK_SINGLE;
            end
            4'd1: begin
                o_lead.kind = LK_STRAY;
            end
            4'd8: begin
                o_lead.kind = LK_INVALID;
            end
            default: begin
                o_lead.kind    = LK_LEAD;
                o_lead.remain  = 3'(w_ones - 4'd1);
                o_lead.payload = i_byte & LEAD_MASK[4'd7 - w_ones];
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/u8dec_accum.sv =====
// Sequence state and accumulation: holds the partial code point and the count
// of continuation bytes still due, and forms the result of each byte.
// Depends on u8dec_pkg and u8dec_lead.
`timescale 1ns / 1ps
`default_nettype none

module u8dec_accum (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    output u8dec_pkg::t_result      o_result
);
    import u8dec_pkg::*;

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [2:0]  r_remain;
    logic [2:0]  n_remain;
    t_lead_info  w_lead;
    logic [31:0] w_shifted;
    logic [2:0]  w_dec;

    u8dec_lead u_lead (
        .i_byte (i_byte),
        .o_lead (w_lead)
    );

    assign w_shifted = {r_acc[25:0], i_byte[5:0]};
    assign w_dec     = r_remain - 3'd1;

    // Next state and result for the byte in the input register.
    always_comb begin
        n_acc               = r_acc;
        n_remain            = r_remain;
        o_result.valid      = 1'b0;
        o_result.code_point = 32'd0;
        o_result.status     = ST_OK;
        if (r_remain != 3'd0) begin
            // Inside a sequence every byte counts as a continuation.
            if (w_dec == 3'd0) begin
                o_result.valid      = 1'b1;
                o_result.code_point = w_shifted;
                n_acc               = 32'd0;
                n_remain            = 3'd0;
            end else if (i_last) begin
                o_result.valid  = 1'b1;
                o_result.status = ST_TRUNCATED;
                n_acc           = 32'd0;
                n_remain        = 3'd0;
            end else begin
                n_acc    = w_shifted;
                n_remain = w_dec;
            end
        end else begin
            case (w_lead.kind)
                LK_SINGLE: begin
                    o_result.valid      = 1'b1;
                    o_result.code_point = {24'd0, i_byte};
                end
                LK_STRAY: begin
                    o_result.valid  = 1'b1;
                    o_result.status = ST_STRAY;
                end
                LK_INVALID: begin
                    o_result.valid  = 1'b1;
                    o_result.status = ST_INVALID;
                end
                LK_LEAD: begin
                    if (i_last) begin
                        o_result.valid  = 1'b1;
                        o_result.status = ST_TRUNCATED;
                    end else begin
                        n_acc    = {24'd0, w_lead.payload};
                        n_remain = w_lead.remain;
                    end
                end
                default: begin
                    o_result.valid = 1'b0;
                end
            endcase
        end
        // Nothing is produced unless the byte moves on this cycle.
        if (!i_fire) begin
            o_result.valid = 1'b0;
        end
    end

    // State registers update only when the byte is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 32'd0;
            r_remain <= 3'd0;
        end else if (i_fire) begin
            r_acc    <= n_acc;
            r_remain <= n_remain;
        end
    end

endmodule

`default_nettype wire

// ===== bench/utf8_dec_checker.sv =====
// Checker for the UTF-8 to UTF-32 decoder: watches both channels, predicts
// each byte's result and compares it with the result beats that come out.
// Depends on u8dec_pkg for the status codes and the lead byte masks.
`timescale 1ns / 1ps

module utf8_dec_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_end,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] i_out_code_point,
    input  wire logic [1:0]  i_out_status,
    output int               o_fail_count,
    output int               o_pending
);
    import u8dec_pkg::*;

    typedef struct packed {
        logic [31:0] code_point;
        logic [1:0]  status;
    } t_char_beat;

    t_char_beat  expected_chars [$];
    logic [31:0] partial_value      = '0;
    logic [2:0]  continuations_left = '0;
    int          fail_total         = 0;
    int          pending_total      = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic int count_leading_ones(input logic [7:0] value);
        int ones;
        ones = 0;
        while (ones < 8 && value[7 - ones]) begin
            ones++;
        end
        return ones;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_total++;
        $display("[%0t] decoder mismatch: %s: got 0x%08h, expected 0x%08h",
                 $realtime, what, got, want);
    endtask

    // Advance the decoder state by one byte and queue the result it causes.
    task automatic decode_byte(input logic [7:0] value, input logic is_last);
        int ones;
        ones = count_leading_ones(value);
        if (continuations_left != 3'd0) begin
            // Inside a sequence every byte is payload, whatever its top bits.
            partial_value      = {partial_value[25:0], value[5:0]};
            continuations_left = continuations_left - 3'd1;
            if (continuations_left == 3'd0) begin
                expected_chars.push_back('{partial_value, ST_OK});
                partial_value = '0;
            end else if (is_last) begin
                partial_value      = '0;
                continuations_left = '0;
                expected_chars.push_back('{32'd0, ST_TRUNCATED});
            end
        end else if (ones == 0) begin
            expected_chars.push_back('{{24'd0, value}, ST_OK});
        end else if (ones == 1) begin
            expected_chars.push_back('{32'd0, ST_STRAY});
        end else if (ones == 8) begin
            expected_chars.push_back('{32'd0, ST_INVALID});
        end else if (is_last) begin
            expected_chars.push_back('{32'd0, ST_TRUNCATED});
        end else begin
            partial_value      = {24'd0, value & LEAD_MASK[7 - ones]};
            continuations_left = 3'(ones - 1);
        end
    endtask

    // Check the result beat first, then predict from the byte beat.
    always @(posedge i_clk) begin
        t_char_beat want;
        if (!i_rst_n) begin
            expected_chars.delete();
            partial_value      = '0;
            continuations_left = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("result beat with nothing expected",
                                    i_out_code_point, 32'd0);
                end else begin
                    want = expected_chars.pop_front();
                    if (i_out_code_point !== want.code_point) begin
                        report_mismatch("code_point", i_out_code_point,
                                        want.code_point);
                    end
                    if (i_out_status !== want.status) begin
                        report_mismatch("status", {30'd0, i_out_status},
                                        {30'd0, want.status});
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_byte, i_in_end);
            end
        end
        pending_total <= expected_chars.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for utf8_to_utf32_decoder: clock, reset, byte stimulus and
// random output stalls. Depends on the decoder RTL and on utf8_dec_checker.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_BEATS = 1750;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 10;

    // Directed bytes as {end_of_text, data_byte}: single bytes at both ends,
    // stray continuations, 0xFF alone and with the end mark, complete 2- and
    // 3-byte characters, truncation on a lead and on a continuation byte, and
    // a 7-byte sequence carrying 0xFF and 0x00 as payload (the value wraps).
    localparam logic [8:0] DIRECTED_BEATS [0:22] = '{
        9'h000, 9'h17F, 9'h080, 9'h1BF, 9'h0FF, 9'h1FF,
        9'h0C2, 9'h0A9, 9'h0DF, 9'h0BF,
        9'h0E2, 9'h082, 9'h1AC,
        9'h1F0, 9'h0E2, 9'h182,
        9'h0FE, 9'h0FF, 9'h000, 9'h03F, 9'h0C0, 9'h080, 9'h1BF
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_data_byte   = '0;
    logic        i_end_of_text = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_code_point;
    logic [1:0]  o_status;

    int fail_count;
    int pending;
    int beats_sent  = 0;
    int cycle_count = 0;
    int stall_hold  = 0;
    bit quiet_phase = 1'b0;

    utf8_to_utf32_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_code_point  (o_code_point),
        .o_status      (o_status)
    );

    utf8_dec_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_data_byte),
        .i_in_end         (i_end_of_text),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_out_code_point (o_code_point),
        .i_out_status     (o_status),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always #1 i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_length();
        int roll;
        if (quiet_phase) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Output stall: alternate runs of ready and stalled cycles.
    always @(posedge i_clk) begin
        bit stall_now;
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stall_now = !quiet_phase && ($urandom_range(0, 2) == 0);
            i_stall <= stall_now;
            stall_hold = stall_now ? idle_length() : $urandom_range(0, 8);
        end
    end

    // Present one byte beat, hold it until taken, then idle for a while.
    task automatic send_beat(input logic [7:0] value, input logic mark_end);
        int gap;
        i_valid       <= 1'b1;
        i_data_byte   <= value;
        i_end_of_text <= mark_end;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        beats_sent++;
        gap = idle_length();
        if (gap > 0) begin
            i_valid       <= 1'b0;
            i_data_byte   <= 8'($urandom);
            i_end_of_text <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lead byte of a character that is len bytes long, random payload.
    function automatic logic [7:0] lead_for_length(input int len);
        logic [7:0] ones;
        logic [7:0] payload;
        if (len == 1) begin
            return 8'($urandom_range(0, 127));
        end
        ones    = 8'hFF << (8 - len);
        payload = 8'($urandom) & ((8'd1 << (7 - len)) - 8'd1);
        return ones | payload;
    endfunction

    // Send the first count bytes of a len-byte character; the byte at
    // bad_pos, if any, is replaced by an arbitrary one.
    task automatic send_char(input int len, input int count, input logic mark_end,
                             input int bad_pos);
        logic [7:0] next_byte;
        for (int k = 0; k < count; k++) begin
            if (k == 0) begin
                next_byte = lead_for_length(len);
            end else if (k == bad_pos) begin
                next_byte = 8'($urandom_range(0, 255));
            end else begin
                next_byte = {2'b10, 6'($urandom)};
            end
            send_beat(next_byte, mark_end && (k == count - 1));
        end
    endtask

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            return 1;
        end
        if (roll < 50) begin
            return 2;
        end
        if (roll < 70) begin
            return 3;
        end
        if (roll < 85) begin
            return 4;
        end
        return $urandom_range(5, 7);
    endfunction

    // Stimulus: reset, directed bytes, then mostly well-formed random text.
    initial begin
        int roll;
        int len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_BEATS[idx]) begin
            send_beat(DIRECTED_BEATS[idx][7:0], DIRECTED_BEATS[idx][8]);
        end

        while (beats_sent < RANDOM_BEATS + $size(DIRECTED_BEATS)) begin
            // Every fifth stretch runs at full rate on both sides.
            quiet_phase = ((beats_sent / 150) % 5 == 2);
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                len = pick_length();
                send_char(len, len, $urandom_range(0, 9) == 0, -1);
            end else if (roll < 77) begin
                len = $urandom_range(2, 7);
                send_char(len, $urandom_range(1, len - 1), 1'b1, -1);
            end else if (roll < 87) begin
                len = $urandom_range(2, 7);
                send_char(len, len, $urandom_range(0, 9) == 0,
                          $urandom_range(1, len - 1));
            end else begin
                send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
        quiet_phase = 1'b0;

        // Drain: wait for every expected result, then run on for DRAIN_CYCLES.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
